>>> rtl/pdcm_pkg.sv
// Shared types and constants for the PWM duty capture meter.
package pdcm_pkg;

   // Field widths
   localparam int unsigned TICK_W   = 16;
   localparam int unsigned DUTY_W   = 15;
   localparam int unsigned WARM_W   = 2;
   localparam int unsigned CNT_W    = 4;
   localparam int unsigned REQ_W    = 24;  // 17 bits of fields, padded to bytes
   localparam int unsigned RSP_W    = 64;
   localparam int unsigned CSR_IDX_W = 1;

   // Behavior constants
   localparam logic [WARM_W-1:0] WARMUP_EDGES = 2'd2;
   localparam logic [TICK_W-1:0] PERIOD_MIN_RESET = 16'd4000;
   localparam logic [TICK_W-1:0] PERIOD_MAX_RESET = 16'd9000;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 15'h7FFF;
   localparam logic [DUTY_W-1:0] DUTY_ZERO = 15'h0000;
   localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(TICK_W - 1);

   // Request kinds carried on tuser
   localparam logic CMD_EDGE     = 1'b0;
   localparam logic CMD_OVERFLOW = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD_MIN = 1'b0,
      CSR_PERIOD_MAX = 1'b1
   } csr_index_type;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

>>> rtl/pwm_duty_capture_meter_core.sv
// PWM duty capture meter: edge/overflow events in, duty and period report out.
//
// req_ channel: one beat per timer event. tuser is the kind (edge or counter
// overflow), tdata carries the tick count since the previous edge and the
// sampled pin level. rsp_ channel: exactly one beat per request, reporting
// the Q15 low-time fraction, the 16-bit period and both half times.
// csr_ port: plain write of the period window limits; write only between
// items, since a write takes effect at the next edge.
// Timing: a request is taken in the idle state; the next cycle forms the period
// and checks the window. When the duty must be recomputed, a restoring
// divider produces the 16-bit quotient one bit per cycle before the report
// step; all other items go straight from the check to the report step.
// req_tready is high only between items.
// The result sits in an output register; the next request is accepted while
// it waits, and the block holds in its final step if the receiver stalls
// with the register still full.
// Reset (synchronous, active high) clears the measurement state, restores
// the window limits to 4000 and 9000, and empties the output register.
module pwm_duty_capture_meter_core (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [15:0] capture_count, [16] pin_level, [23:17] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pdcm_pkg::REQ_W-1:0]          req_tdata,
   // req_tuser: [0] cmd
   input  logic                                req_tuser,
   // rsp_tdata: [14:0] duty_fraction, [30:15] period_total, [46:31] high_ticks,
   //            [62:47] low_ticks, [63] awaiting_falling
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pdcm_pkg::RSP_W-1:0]          rsp_tdata,
   input  logic                                csr_we,
   input  logic [pdcm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdcm_pkg::TICK_W-1:0]         csr_wdata
);
   import pdcm_pkg::*;

   state_type           state_ff, state_in;
   logic [TICK_W-1:0]   cfg_min_ff, cfg_min_in;
   logic [TICK_W-1:0]   cfg_max_ff, cfg_max_in;
   logic                expect_ff, expect_in;
   logic [TICK_W-1:0]   high_ff, high_in;
   logic [TICK_W-1:0]   low_ff, low_in;
   logic [WARM_W-1:0]   warm_ff, warm_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;
   logic                upd_ff, upd_in;
   logic [TICK_W-1:0]   period_ff, period_in;
   logic [TICK_W-1:0]   div_ff, div_in;
   logic [TICK_W-1:0]   rem_ff, rem_in;
   logic [TICK_W-1:0]   num_ff, num_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [TICK_W-1:0]     req_count;
   logic                  req_pin;
   logic [TICK_W-1:0]     period_sum;
   logic                  in_window;
   logic [2*TICK_W-1:0]   dividend;
   logic [TICK_W+1:0]     trial;
   logic                  trial_ge;
   logic                  out_free;

   assign req_count  = req_tdata[TICK_W-1:0];
   assign req_pin    = req_tdata[TICK_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Period check and divider set-up; low * 65535 = (low << 16) - low
   assign period_sum = high_ff + low_ff;
   assign in_window  = (period_sum > cfg_min_ff) && (period_sum < cfg_max_ff);
   assign dividend   = {low_ff, {TICK_W{1'b0}}} - {{TICK_W{1'b0}}, low_ff};

   // One restoring divide step
   assign trial    = {1'b0, rem_ff, num_ff[TICK_W-1]} - {2'b00, div_ff};
   assign trial_ge = !trial[TICK_W+1];

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      cfg_min_in   = cfg_min_ff;
      cfg_max_in   = cfg_max_ff;
      expect_in    = expect_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      warm_in      = warm_ff;
      duty_in      = duty_ff;
      upd_in       = upd_ff;
      period_in    = period_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // Window register writes
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PERIOD_MIN: cfg_min_in = csr_wdata;
            CSR_PERIOD_MAX: cfg_max_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               upd_in   = 1'b0;
               state_in = ST_CHECK;
               if (req_tuser == CMD_OVERFLOW) begin
                  // timer wrapped without an edge: pin stuck
                  warm_in = '0;
                  if (req_pin) begin
                     duty_in   = DUTY_ZERO;
                     low_in    = '0;
                     expect_in = 1'b1;
                  end else begin
                     duty_in   = DUTY_MAX;
                     high_in   = '0;
                     expect_in = 1'b0;
                  end
               end else begin
                  if (expect_ff) begin
                     high_in = req_count;
                     if (req_pin) low_in = '0;
                     else expect_in = 1'b0;
                  end else begin
                     low_in = req_count;
                     if (!req_pin) high_in = '0;
                     else expect_in = 1'b1;
                  end
                  if (warm_ff < WARMUP_EDGES) begin
                     warm_in = warm_ff + 1'b1;
                  end else begin
                     upd_in = 1'b1;
                  end
               end
            end
         end
         ST_CHECK: begin
            period_in = period_sum;
            state_in  = ST_DONE;
            if (upd_ff && in_window) begin
               if (low_ff >= period_sum) begin
                  // quotient would exceed full scale
                  duty_in = DUTY_MAX;
               end else begin
                  rem_in   = dividend[2*TICK_W-1:TICK_W];
                  num_in   = dividend[TICK_W-1:0];
                  div_in   = period_sum;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial[TICK_W-1:0] : {rem_ff[TICK_W-2:0], num_ff[TICK_W-1]};
            num_in = {num_ff[TICK_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               duty_in  = num_in[TICK_W-1:1];
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {expect_ff, low_ff, high_ff, period_ff, duty_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and measurement state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_min_ff   <= PERIOD_MIN_RESET;
         cfg_max_ff   <= PERIOD_MAX_RESET;
         expect_ff    <= 1'b0;
         high_ff      <= '0;
         low_ff       <= '0;
         warm_ff      <= '0;
         duty_ff      <= '0;
         upd_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_min_ff   <= cfg_min_in;
         cfg_max_ff   <= cfg_max_in;
         expect_ff    <= expect_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         warm_ff      <= warm_in;
         duty_ff      <= duty_in;
         upd_ff       <= upd_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      period_ff   <= period_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Divider partial remainder stays below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   // Step counter only runs during the divide
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (cnt_ff == '0))
      else $error("divide counter active outside divide");

   // Warm-up count never passes its limit
   a_warm_limit: assert property (@(posedge clock) disable iff (reset)
      warm_ff <= WARMUP_EDGES)
      else $error("warm-up count out of range");

   // Overflow with pin high forces duty to zero
   a_ovf_high: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == CMD_OVERFLOW && req_pin) |=> (duty_ff == DUTY_ZERO))
      else $error("overflow with pin high did not clear duty");

endmodule

>>> tb/pdcm_meter_checker.sv
// Scoreboard for the PWM duty capture meter: predicts every report beat and checks the rsp_ stream.
`timescale 1ns / 100ps

module pdcm_meter_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [pdcm_pkg::REQ_W-1:0]     req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [pdcm_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                           csr_we,
   input  logic [pdcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdcm_pkg::TICK_W-1:0]    csr_wdata,
   output int unsigned                    fail_count,
   output int unsigned                    pending_beats,
   output int unsigned                    checked_beats
);
   import pdcm_pkg::*;

   // Report layout, MSB first so it overlays rsp_tdata directly
   typedef struct packed {
      logic              falling;
      logic [TICK_W-1:0] low;
      logic [TICK_W-1:0] high;
      logic [TICK_W-1:0] period;
      logic [DUTY_W-1:0] duty;
   } meter_report_type;

   // Shadow window and measurement state
   logic [TICK_W-1:0] win_min;
   logic [TICK_W-1:0] win_max;
   logic              expect_fall;
   logic [TICK_W-1:0] high_t;
   logic [TICK_W-1:0] low_t;
   logic [WARM_W-1:0] warm_cnt;
   logic [DUTY_W-1:0] duty_q;

   meter_report_type report_q[$];
   int unsigned      mismatches = 0;
   int unsigned      checked = 0;

   // Q15 low fraction; the window test guarantees a nonzero period here.
   // A wrapped period can be smaller than the low time, hence the clamp.
   function automatic logic [DUTY_W-1:0] low_fraction(input logic [TICK_W-1:0] lo,
                                                      input logic [TICK_W-1:0] per);
      logic [31:0] q;
      q = (({16'd0, lo} * 32'h0000_FFFF) / {16'd0, per}) >> 1;
      return (q > {17'd0, DUTY_MAX}) ? DUTY_MAX : q[DUTY_W-1:0];
   endfunction

   // Advance the shadow state by one event and form its report
   task automatic measure_event(input logic cmd, input logic [TICK_W-1:0] cnt,
                                input logic pin, output meter_report_type rep);
      logic [TICK_W-1:0] per;
      if (cmd == CMD_OVERFLOW) begin
         // counter ran out: pin level decides full-high or full-low
         if (pin) begin
            duty_q      = DUTY_ZERO;
            low_t       = '0;
            expect_fall = 1'b1;
         end else begin
            duty_q      = DUTY_MAX;
            high_t      = '0;
            expect_fall = 1'b0;
         end
         warm_cnt = '0;
         per      = high_t + low_t;
      end else begin
         if (expect_fall) begin
            high_t = cnt;
            if (pin) low_t = '0;         // pulse already over, keep direction
            else expect_fall = 1'b0;
         end else begin
            low_t = cnt;
            if (!pin) high_t = '0;
            else expect_fall = 1'b1;
         end
         per = high_t + low_t;
         if (warm_cnt < WARMUP_EDGES) begin
            warm_cnt = warm_cnt + 1'b1;
         end else if (per > win_min && per < win_max) begin
            duty_q = low_fraction(low_t, per);
         end
      end
      rep = '{falling: expect_fall, low: low_t, high: high_t, period: per, duty: duty_q};
   endtask

   always @(posedge clock) begin : scoreboard
      meter_report_type got;
      meter_report_type want;
      if (reset) begin
         win_min     = PERIOD_MIN_RESET;
         win_max     = PERIOD_MAX_RESET;
         expect_fall = 1'b0;
         high_t      = '0;
         low_t       = '0;
         warm_cnt    = '0;
         duty_q      = DUTY_ZERO;
         report_q.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PERIOD_MIN: win_min = csr_wdata;
               CSR_PERIOD_MAX: win_max = csr_wdata;
               default: ;
            endcase
         end

         // report beat against oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (report_q.size() == 0) begin
               $error("report beat with nothing pending: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = report_q.pop_front();
               checked++;
               if (got.duty !== want.duty) begin
                  $error("duty_fraction: expected %0d, got %0d", want.duty, got.duty);
                  mismatches++;
               end
               if (got.period !== want.period) begin
                  $error("period_total: expected %0d, got %0d", want.period, got.period);
                  mismatches++;
               end
               if (got.high !== want.high) begin
                  $error("high_ticks: expected %0d, got %0d", want.high, got.high);
                  mismatches++;
               end
               if (got.low !== want.low) begin
                  $error("low_ticks: expected %0d, got %0d", want.low, got.low);
                  mismatches++;
               end
               if (got.falling !== want.falling) begin
                  $error("awaiting_falling: expected %0d, got %0d", want.falling, got.falling);
                  mismatches++;
               end
            end
         end

         // event beat: predict its report
         if (req_tvalid && req_tready) begin
            measure_event(req_tuser, req_tdata[TICK_W-1:0], req_tdata[TICK_W], want);
            report_q.push_back(want);
         end
      end
      fail_count    <= mismatches;
      pending_beats <= report_q.size();
      checked_beats <= checked;
   end

endmodule

>>> tb/pwm_duty_capture_meter_core_tb.sv
// Top testbench for the PWM duty capture meter: clock, reset, event and window stimulus, verdict.
`timescale 1ns / 100ps

module pwm_duty_capture_meter_core_tb;
   import pdcm_pkg::*;

   localparam int unsigned SETTLE_CYCLES  = 40;    // beyond the slowest item
   localparam int unsigned HOLDOFF_CYCLES = 400;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned PHASES         = 8;
   localparam int unsigned PHASE_BEATS    = 110;

   // directed events, packed as {cmd, pin, count}
   localparam logic [17:0] DIRECTED_STD [18] = '{
      {CMD_EDGE,     1'b1, 16'd3000},   // warm-up
      {CMD_EDGE,     1'b0, 16'd3000},   // warm-up
      {CMD_EDGE,     1'b1, 16'd2000},   // in window
      {CMD_EDGE,     1'b0, 16'd4000},
      {CMD_EDGE,     1'b0, 16'd1000},   // pin still low, high cleared
      {CMD_EDGE,     1'b1, 16'd4000},   // period equals minimum
      {CMD_EDGE,     1'b1, 16'd5000},   // pin still high, low cleared
      {CMD_EDGE,     1'b0, 16'd9000},   // period equals maximum
      {CMD_EDGE,     1'b1, 16'hFFFF},   // sum wraps, low above period
      {CMD_OVERFLOW, 1'b1, 16'hFFFF},   // overflow with pin high
      {CMD_EDGE,     1'b0, 16'd0},
      {CMD_EDGE,     1'b1, 16'hFFFF},
      {CMD_OVERFLOW, 1'b0, 16'd0},      // overflow with pin low
      {CMD_EDGE,     1'b1, 16'd4001},
      {CMD_EDGE,     1'b0, 16'd4998},
      {CMD_EDGE,     1'b1, 16'd4000},
      {CMD_EDGE,     1'b0, 16'd1},      // just above minimum
      {CMD_OVERFLOW, 1'b1, 16'd12345}
   };

   // directed events for the full-open window (min 0, max 65535)
   localparam logic [17:0] DIRECTED_WIDE [7] = '{
      {CMD_OVERFLOW, 1'b0, 16'd0},
      {CMD_EDGE,     1'b1, 16'd0},
      {CMD_EDGE,     1'b0, 16'd0},
      {CMD_EDGE,     1'b1, 16'd0},      // zero period with zero minimum
      {CMD_EDGE,     1'b0, 16'd1},      // smallest usable period
      {CMD_EDGE,     1'b1, 16'hFFFE},   // period at maximum, excluded
      {CMD_EDGE,     1'b0, 16'd2}       // sum wraps to zero
   };

   // per-phase window and idle mix
   localparam int unsigned WIN_LO [PHASES] = '{4000, 0, 65535, 2000, 0, 5000, 0, 4000};
   localparam int unsigned WIN_HI [PHASES] = '{9000, 65535, 0, 12000, 65535, 5200, 0, 9000};
   localparam int unsigned SEND_IDLE [4]   = '{0, 49, 0, 28};
   localparam int unsigned RECV_STALL [4]  = '{0, 0, 49, 28};

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICK_W-1:0]    csr_wdata;

   int unsigned fail_count;
   int unsigned pending_beats;
   int unsigned checked_beats;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned beats_sent = 0;
   int unsigned quiet_cycles = 0;
   logic        holdoff_req = 1'b0;

   pwm_duty_capture_meter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pdcm_meter_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_beats (pending_beats),
      .checked_beats (checked_beats)
   );

   // 100 MHz clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: too long without any beat or write ends the run
   always @(posedge clock) begin
      if (csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Report side: random stalls, plus one long hold-off on request
   initial begin : report_sink
      int unsigned n;
      logic        holdoff_done;
      rsp_tready   = 1'b0;
      holdoff_done = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_req && !holdoff_done) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < HOLDOFF_CYCLES; n++) @(posedge clock);
            holdoff_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offer one event beat, with optional idle cycles ahead of it
   task automatic send_beat(input logic cmd, input logic [TICK_W-1:0] cnt, input logic pin);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_W-TICK_W-1){1'b0}}, pin, cnt};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   // Drain all reports, let the block go quiet, then write the window
   task automatic set_window(input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] hi);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_PERIOD_MIN;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_PERIOD_MAX;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned i;
      int unsigned r;
      int unsigned lo;
      int unsigned hi;
      int unsigned span_lo;
      int unsigned span_hi;
      int unsigned total;
      logic [TICK_W-1:0] high_len;
      logic [TICK_W-1:0] low_len;
      logic pwm_pin;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_EDGE;
      csr_we     = 1'b0;
      csr_index  = CSR_PERIOD_MIN;
      csr_wdata  = '0;
      pwm_pin    = 1'b0;
      high_len   = 16'd3000;
      low_len    = 16'd3000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset window first, then the full-open window
      foreach (DIRECTED_STD[k])
         send_beat(DIRECTED_STD[k][17], DIRECTED_STD[k][15:0], DIRECTED_STD[k][16]);
      set_window(16'd0, 16'hFFFF);
      foreach (DIRECTED_WIDE[k])
         send_beat(DIRECTED_WIDE[k][17], DIRECTED_WIDE[k][15:0], DIRECTED_WIDE[k][16]);

      // random phases over windows and idle mixes
      for (phase = 0; phase < PHASES; phase++) begin
         lo = WIN_LO[phase];
         hi = WIN_HI[phase];
         if (phase == 6) begin
            lo = $urandom_range(8000, 0);
            hi = lo + $urandom_range(8000, 1);
         end
         set_window(lo[TICK_W-1:0], hi[TICK_W-1:0]);
         idle_pct  = SEND_IDLE[phase % 4];
         stall_pct = RECV_STALL[phase % 4];

         // period range: around the window, or 1 to 20000 when it is shut
         if (hi > lo + 1) begin
            span_lo = (lo > 500) ? lo - 500 : 0;
            span_hi = (hi < 65035) ? hi + 500 : 65535;
         end else begin
            span_lo = 1;
            span_hi = 20000;
         end

         for (i = 0; i < PHASE_BEATS; i++) begin
            // long output hold-off while events keep coming
            if (phase == 0 && i == 30) holdoff_req <= 1'b1;
            r = $urandom_range(99);
            if (r < 8) begin
               send_beat(CMD_OVERFLOW, TICK_W'($urandom), 1'($urandom));
            end else if (r < 20) begin
               send_beat(CMD_EDGE, TICK_W'($urandom), 1'($urandom));
            end else begin
               // well-formed waveform: alternate edges, occasional new period
               if ($urandom_range(9) == 0) begin
                  total    = $urandom_range(span_hi, span_lo);
                  high_len = TICK_W'($urandom_range(total, 0));
                  low_len  = TICK_W'(total) - high_len;
               end
               pwm_pin = !pwm_pin;
               send_beat(CMD_EDGE, pwm_pin ? low_len : high_len, pwm_pin);
            end
         end
      end

      // drain and allow for a stray late report
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d event beats (edges, overflows, noise) and %0d checked reports",
               beats_sent, checked_beats);
      $display("over %0d window settings, four idle/stall mixes and one long output hold-off",
               PHASES + 2);
      if (fail_count == 0 && pending_beats == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/pdcm_pkg.sv
rtl/pwm_duty_capture_meter_core.sv
tb/pdcm_meter_checker.sv
tb/pwm_duty_capture_meter_core_tb.sv
